### hdl/min_heap_timer_queue_macros.svh
// Assertion helpers used by the timer queue datapath
`ifndef MIN_HEAP_TIMER_QUEUE_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_MACROS_SVH

// Check a property outside of reset
`define MHTQ_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included
`define MHTQ_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mhtq_pkg.sv
package mhtq_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ADDED    = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_DELETED  = 3'd2,
        KIND_NOTFOUND = 3'd3,
        KIND_FIRED    = 3'd4,
        KIND_NONE     = 3'd5
    } kind_t;

    // Request modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_DEL   = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ADD,
        OP_RD_PARENT,
        OP_UP_MOVE,
        OP_PLACE,
        OP_RD_POS,
        OP_DEL_START,
        OP_POP_START,
        OP_LOAD_LAST,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_DN_MOVE,
        OP_RD_ROOT,
        OP_HOLD_ROOT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        kind_t      kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       full;
        logic       empty;
        logic       pos_zero;
        logic       up_less;
        logic       has_left;
        logic       down_move;
        logic       moved;
        logic       pos_is_last;
        logic       due;
        logic       pend_have;
        logic       out_free;
        logic       tid_hit;
    } status_t;

endpackage

### hdl/mhtq_ram.sv
module mhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

### hdl/mhtq_ctrl.sv
module mhtq_ctrl
    import mhtq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD, S_DEL, S_DEL_POS, S_REM_CHK, S_DN_RDL, S_DN_RDR, S_DN_CMP,
        S_DN_END, S_UP_RD, S_UP_CMP, S_PLACE, S_CHK_PEEK, S_CHK_DEC, S_CHK_POP, S_EMIT
    } state_t;

    typedef enum logic [1:0] {CTX_ADD, CTX_DEL, CTX_CHK} ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;
    kind_t  ekind_reg, ekind_next;
    logic   elast_reg, elast_next;
    logic   emid_reg, emid_next;

    assign s_tready = (state_reg == S_IDLE);

    // Sequence the datapath
    always_comb begin
        state_t fin;
        fin = S_CHK_PEEK;
        case (ctx_reg)
            CTX_ADD: fin = S_EMIT;
            CTX_DEL: fin = S_EMIT;
            default: fin = S_CHK_PEEK;
        endcase
        state_next = state_reg;
        ctx_next   = ctx_reg;
        ekind_next = ekind_reg;
        elast_next = elast_reg;
        emid_next  = emid_reg;
        cmd.op     = OP_NONE;
        cmd.kind   = ekind_reg;
        cmd.last   = elast_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = OP_CAPTURE;
                    case (st.in_mode)
                        MODE_ADD:   begin state_next = S_ADD; ctx_next = CTX_ADD; end
                        MODE_DEL:   begin state_next = S_DEL; ctx_next = CTX_DEL; end
                        MODE_CHECK: begin state_next = S_CHK_PEEK; ctx_next = CTX_CHK; end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (st.full) begin
                    ekind_next = KIND_FULL; elast_next = 1'b1; emid_next = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    cmd.op = OP_ADD;
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (st.pos_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op = OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (st.up_less) begin
                    cmd.op = OP_UP_MOVE;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE, S_REM_CHK: begin
                if (state_reg == S_PLACE || st.pos_is_last) begin
                    if (state_reg == S_PLACE) begin
                        cmd.op = OP_PLACE;
                    end
                    state_next = fin;
                    ekind_next = (ctx_reg == CTX_ADD) ? KIND_ADDED : KIND_DELETED;
                    elast_next = 1'b1;
                    emid_next  = 1'b0;
                end else begin
                    cmd.op = OP_LOAD_LAST;
                    state_next = S_DN_RDL;
                end
            end
            S_DEL: begin
                if (!st.tid_hit) begin
                    ekind_next = KIND_NOTFOUND; elast_next = 1'b1; emid_next = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    cmd.op = OP_RD_POS;
                    state_next = S_DEL_POS;
                end
            end
            S_DEL_POS: begin
                cmd.op = OP_DEL_START;
                state_next = S_REM_CHK;
            end
            S_DN_RDL: begin
                if (st.has_left) begin
                    cmd.op = OP_RD_LEFT;
                    state_next = S_DN_RDR;
                end else begin
                    state_next = S_DN_END;
                end
            end
            S_DN_RDR: begin
                cmd.op = OP_RD_RIGHT;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (st.down_move) begin
                    cmd.op = OP_DN_MOVE;
                    state_next = S_DN_RDL;
                end else begin
                    state_next = S_DN_END;
                end
            end
            S_DN_END: begin
                state_next = st.moved ? S_PLACE : S_UP_RD;
            end
            S_CHK_PEEK: begin
                if (st.empty) begin
                    ekind_next = st.pend_have ? KIND_FIRED : KIND_NONE;
                    elast_next = 1'b1; emid_next = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    cmd.op = OP_RD_ROOT;
                    state_next = S_CHK_DEC;
                end
            end
            S_CHK_DEC: begin
                if (!st.due) begin
                    ekind_next = st.pend_have ? KIND_FIRED : KIND_NONE;
                    elast_next = 1'b1; emid_next = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    cmd.op = OP_HOLD_ROOT;
                    if (st.pend_have) begin
                        ekind_next = KIND_FIRED; elast_next = 1'b0; emid_next = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_CHK_POP;
                    end
                end
            end
            S_CHK_POP: begin
                cmd.op = OP_POP_START;
                state_next = S_REM_CHK;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.op = OP_EMIT;
                    state_next = emid_reg ? S_CHK_POP : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and emit settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctx_reg   <= CTX_ADD;
            ekind_reg <= KIND_NONE;
            elast_reg <= 1'b0;
            emid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            ekind_reg <= ekind_next;
            elast_reg <= elast_next;
            emid_reg  <= emid_next;
        end
    end

endmodule

### hdl/mhtq_dp.sv
`include "min_heap_timer_queue_macros.svh"
module mhtq_dp
    import mhtq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  cmd_t        cmd,
    output status_t     st,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int PW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = PW + 2;
    localparam int EW = PW + TIME_BITS;

    // Captured request
    logic [TIME_BITS-1:0] now_reg, delay_reg;
    logic [5:0]           tid_reg;

    logic [SW-1:0]        size_reg;
    logic [PW-1:0]        pos_reg, start_reg;
    logic [PW-1:0]        cur_slot_reg;
    logic [TIME_BITS-1:0] cur_dl_reg;
    logic [EW-1:0]        lt_reg;
    logic [EW-1:0]        root_reg;
    logic [PW-1:0]        pend_slot_reg;
    logic [TIME_BITS-1:0] pend_dl_reg;
    logic                 pend_have_reg;
    logic [CAPACITY-1:0]  valid_reg;

    logic                 m_valid_reg;
    logic [2:0]           m_kind_reg;
    logic [5:0]           m_id_reg;
    logic [31:0]          m_dl_reg;
    logic                 m_last_reg;

    // Heap and slot position memories
    logic          h_we, h_re;
    logic [PW-1:0] h_waddr, h_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    logic          p_we, p_re;
    logic [PW-1:0] p_waddr, p_raddr;
    logic [PW-1:0] p_wdata, p_rdata;

    mhtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
    );

    mhtq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
    );

    // Index arithmetic
    logic [IW-1:0]        left_idx, right_idx;
    logic [PW-1:0]        parent_idx;
    logic [PW-1:0]        r_slot;
    logic [TIME_BITS-1:0] r_dl, l_dl;
    logic                 take_right;
    logic [EW-1:0]        best_ent;
    logic [PW-1:0]        best_idx;
    logic [SW-1:0]        size_dec;
    logic [PW-1:0]        free_slot;
    logic [TIME_BITS-1:0] add_dl;

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign parent_idx = (pos_reg - PW'(1)) >> 1;
    assign r_slot     = h_rdata[EW-1:TIME_BITS];
    assign r_dl       = h_rdata[TIME_BITS-1:0];
    assign l_dl       = lt_reg[TIME_BITS-1:0];
    assign take_right = (right_idx < IW'(size_reg)) && !(l_dl < r_dl);
    assign best_ent   = take_right ? h_rdata : lt_reg;
    assign best_idx   = take_right ? right_idx[PW-1:0] : left_idx[PW-1:0];
    assign size_dec   = size_reg - SW'(1);
    assign add_dl     = now_reg + delay_reg;

    // Find the lowest free slot
    always_comb begin
        logic found;
        found     = 1'b0;
        free_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!valid_reg[i] && !found) begin
                free_slot = PW'(i);
                found     = 1'b1;
            end
        end
    end

    // Status toward the controller
    assign st.in_mode     = s_tuser;
    assign st.full        = (size_reg == SW'(CAPACITY));
    assign st.empty       = (size_reg == '0);
    assign st.pos_zero    = (pos_reg == '0);
    assign st.up_less     = (cur_dl_reg < r_dl);
    assign st.has_left    = (left_idx < IW'(size_reg));
    assign st.down_move   = (best_ent[TIME_BITS-1:0] < cur_dl_reg);
    assign st.moved       = (pos_reg != start_reg);
    assign st.pos_is_last = (SW'(pos_reg) == size_reg);
    assign st.due         = !(now_reg < r_dl);
    assign st.pend_have   = pend_have_reg;
    assign st.out_free    = !m_valid_reg || m_tready;
    assign st.tid_hit     = (7'(tid_reg) < 7'(CAPACITY)) && valid_reg[tid_reg[PW-1:0]];

    // Memory port control
    always_comb begin
        h_we = 1'b0; h_waddr = pos_reg; h_wdata = {cur_slot_reg, cur_dl_reg};
        h_re = 1'b0; h_raddr = '0;
        p_we = 1'b0; p_waddr = cur_slot_reg; p_wdata = pos_reg;
        p_re = 1'b0; p_raddr = tid_reg[PW-1:0];
        case (cmd.op)
            OP_RD_PARENT: begin h_re = 1'b1; h_raddr = parent_idx; end
            OP_UP_MOVE: begin
                h_we = 1'b1; h_wdata = h_rdata;
                p_we = 1'b1; p_waddr = r_slot;
            end
            OP_PLACE: begin h_we = 1'b1; p_we = 1'b1; end
            OP_RD_POS: p_re = 1'b1;
            OP_DEL_START, OP_POP_START: begin
                h_re = 1'b1; h_raddr = size_dec[PW-1:0];
            end
            OP_RD_LEFT:  begin h_re = 1'b1; h_raddr = left_idx[PW-1:0]; end
            OP_RD_RIGHT: begin h_re = 1'b1; h_raddr = right_idx[PW-1:0]; end
            OP_DN_MOVE: begin
                h_we = 1'b1; h_wdata = best_ent;
                p_we = 1'b1; p_waddr = best_ent[EW-1:TIME_BITS];
            end
            OP_RD_ROOT: h_re = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            valid_reg     <= '0;
            pend_have_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CAPTURE: pend_have_reg <= 1'b0;
                OP_ADD: begin
                    size_reg <= size_reg + SW'(1);
                    valid_reg[free_slot] <= 1'b1;
                end
                OP_DEL_START: begin
                    size_reg <= size_dec;
                    valid_reg[tid_reg[PW-1:0]] <= 1'b0;
                end
                OP_POP_START: begin
                    size_reg <= size_dec;
                    valid_reg[root_reg[EW-1:TIME_BITS]] <= 1'b0;
                    pend_have_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                now_reg   <= TIME_BITS'(s_tdata[31:0]);
                delay_reg <= TIME_BITS'(s_tdata[63:32]);
                tid_reg   <= s_tdata[69:64];
            end
            OP_ADD: begin
                cur_slot_reg <= free_slot;
                cur_dl_reg   <= add_dl;
                pos_reg      <= size_reg[PW-1:0];
                start_reg    <= size_reg[PW-1:0];
            end
            OP_UP_MOVE:   pos_reg <= parent_idx;
            OP_DEL_START: pos_reg <= p_rdata;
            OP_POP_START: begin
                pos_reg       <= '0;
                pend_slot_reg <= root_reg[EW-1:TIME_BITS];
                pend_dl_reg   <= root_reg[TIME_BITS-1:0];
            end
            OP_LOAD_LAST: begin
                cur_slot_reg <= r_slot;
                cur_dl_reg   <= r_dl;
                start_reg    <= pos_reg;
            end
            OP_RD_RIGHT:  lt_reg   <= h_rdata;
            OP_DN_MOVE:   pos_reg  <= best_idx;
            OP_HOLD_ROOT: root_reg <= h_rdata;
            OP_EMIT: begin
                m_kind_reg <= cmd.kind;
                m_last_reg <= cmd.last;
                case (cmd.kind)
                    KIND_ADDED: begin
                        m_id_reg <= 6'(cur_slot_reg); m_dl_reg <= 32'(cur_dl_reg);
                    end
                    KIND_FIRED: begin
                        m_id_reg <= 6'(pend_slot_reg); m_dl_reg <= 32'(pend_dl_reg);
                    end
                    KIND_DELETED, KIND_NOTFOUND: begin
                        m_id_reg <= tid_reg; m_dl_reg <= '0;
                    end
                    default: begin
                        m_id_reg <= '0; m_dl_reg <= '0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dl_reg, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `MHTQ_ASSERT_RST(a_size_bound, aclk, aresetn, size_reg <= SW'(CAPACITY), "heap size over capacity")
    `MHTQ_ASSERT_RST(a_count_match, aclk, aresetn, $countones(valid_reg) == 32'(size_reg), "live count mismatch")
    `MHTQ_ASSERT_RST(a_emit_free, aclk, aresetn, cmd.op == OP_EMIT |-> (!m_valid_reg || m_tready), "result overwritten")
    `MHTQ_ASSERT_ALL(a_reset_empty, aclk, !aresetn |=> size_reg == '0, "heap not empty after reset")

endmodule

### hdl/min_heap_timer_queue.sv
// Timer queue kept as a binary min-heap of deadlines (one heap RAM, one slot position RAM).
// Requests are taken one at a time. An add walks up at most log2(CAPACITY) levels.
// A delete walks down and, when the moved entry does not go down, walks up. A check
// pops each due timer, with a walk down from the root for each. The heap RAM's single
// registered read port paces these walks, and output stalls hold them. A result waits
// in an output register, and the next request is taken once the previous one has
// produced all of its results.
module min_heap_timer_queue
    import mhtq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // now_ms[31:0], delay_ms[63:32], timer_id[69:64], zero fill
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_id[5:0], deadline[37:6], zero fill
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast
);

    cmd_t    cmd;
    status_t st;

    mhtq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .st(st), .cmd(cmd)
    );

    mhtq_dp #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd(cmd), .st(st),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

### verif/min_heap_timer_queue_test.sv
module min_heap_timer_queue_test;
    import mhtq_pkg::*;

    localparam int CAP = 64;
    localparam int LIMIT = 2000000;

    typedef struct {
        kind_t       kind;
        logic [5:0]  id;
        logic [31:0] deadline;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] delay_ms;
        logic [5:0]  timer_id;
        logic        typed;
        kind_t       kind;
        logic [5:0]  id;
        logic [31:0] deadline;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    min_heap_timer_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    // Predictor state: shadow heap of slot ids
    logic [5:0]  q_order [CAP];
    logic [31:0] q_deadline [CAP];
    logic [5:0]  q_pos [CAP];
    logic        q_live [CAP];
    int          q_size;

    timer_result_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet_src = 1'b0;
    bit  quiet_snk = 1'b0;

    function automatic logic [31:0] dl_of(int p);
        return q_deadline[q_order[p]];
    endfunction

    function automatic void swap_heap(int a, int b);
        logic [5:0] t;
        t = q_order[a];
        q_order[a] = q_order[b];
        q_order[b] = t;
        q_pos[q_order[a]] = a[5:0];
        q_pos[q_order[b]] = b[5:0];
    endfunction

    function automatic void heap_up(int p);
        int par;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (!(dl_of(p) < dl_of(par))) break;
            swap_heap(par, p);
            p = par;
        end
    endfunction

    function automatic bit heap_down(int p);
        int i, l, r, b;
        i = p;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            b = l;
            if (l >= q_size) break;
            if (r < q_size && !(dl_of(l) < dl_of(r))) b = r;
            if (!(dl_of(b) < dl_of(i))) break;
            swap_heap(i, b);
            i = b;
        end
        return i > p;
    endfunction

    function automatic void heap_remove(int p);
        logic [5:0] s;
        s = q_order[p];
        q_size--;
        if (p != q_size) begin
            q_order[p] = q_order[q_size];
            q_pos[q_order[p]] = p[5:0];
            if (!heap_down(p)) heap_up(p);
        end
        q_live[s] = 1'b0;
    endfunction

    function automatic void push_result(kind_t k, logic [5:0] id, logic [31:0] dl, logic l);
        timer_result_t r;
        r.kind = k; r.id = id; r.deadline = dl; r.last = l;
        pending_results = {pending_results, r};
    endfunction

    // Work out the results of one request and advance the shadow heap
    function automatic void predict_timer_op(logic [1:0] mode, logic [31:0] now_ms,
                                             logic [31:0] delay_ms, logic [5:0] tid);
        int s, n;
        logic [31:0] dl;
        if (mode == MODE_ADD) begin
            if (q_size >= CAP) begin
                push_result(KIND_FULL, 6'd0, 32'd0, 1'b1);
                return;
            end
            s = 0;
            while (s < CAP && q_live[s]) s++;
            dl = now_ms + delay_ms;
            q_live[s] = 1'b1;
            q_deadline[s] = dl;
            q_pos[s] = q_size[5:0];
            q_order[q_size] = s[5:0];
            q_size++;
            heap_up(q_size - 1);
            push_result(KIND_ADDED, s[5:0], dl, 1'b1);
        end else if (mode == MODE_DEL) begin
            if (!q_live[tid]) begin
                push_result(KIND_NOTFOUND, tid, 32'd0, 1'b1);
                return;
            end
            heap_remove(q_pos[tid]);
            push_result(KIND_DELETED, tid, 32'd0, 1'b1);
        end else if (mode == MODE_CHECK) begin
            n = 0;
            while (q_size > 0 && !(now_ms < dl_of(0))) begin
                s = q_order[0];
                dl = q_deadline[s];
                heap_remove(0);
                push_result(KIND_FIRED, s[5:0], dl, 1'b0);
                n++;
            end
            if (n == 0) push_result(KIND_NONE, 6'd0, 32'd0, 1'b1);
            else pending_results[$].last = 1'b1;
        end
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        timer_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d id %0d dl %0d last %0d", $time,
                         m_tuser, m_tdata[5:0], m_tdata[37:6], m_tlast);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind || m_tdata[5:0] !== e.id ||
                    m_tdata[37:6] !== e.deadline || m_tlast !== e.last) begin
                    $display("%0t: expected kind %0d id %0d dl %0d last %0d, got %0d %0d %0d %0d",
                             $time, e.kind, e.id, e.deadline, e.last, m_tuser,
                             m_tdata[5:0], m_tdata[37:6], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= quiet_snk ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("min_heap_timer_queue_test: done, errors");
            $finish;
        end
    end

    // Hold one request until accepted, then predict its results; the next request replaces it
    // or releases tvalid, and a drain releases tvalid, at the following falling edge
    task automatic send_request(logic [1:0] mode, logic [31:0] now_ms,
                                logic [31:0] delay_ms, logic [5:0] tid);
        while (!quiet_src && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, tid, delay_ms, now_ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_timer_op(mode, now_ms, delay_ms, tid);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 64);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    stim_row_t directed [$];

    function automatic void add_row(logic [1:0] m, logic [31:0] nw, logic [31:0] dly,
                                    logic [5:0] tid, logic typed, kind_t k,
                                    logic [5:0] id, logic [31:0] dl);
        stim_row_t r;
        r.mode = m; r.now_ms = nw; r.delay_ms = dly; r.timer_id = tid;
        r.typed = typed; r.kind = k; r.id = id; r.deadline = dl;
        directed = {directed, r};
    endfunction

    initial begin
        logic [31:0] base;
        int sel;
        for (int i = 0; i < CAP; i++) q_live[i] = 1'b0;
        q_size = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: empty queue answers, extremes, wraparound, ties
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 0, 0, 1, KIND_NONE, 0, 0);
        add_row(MODE_DEL, 0, 0, 6'd63, 1, KIND_NOTFOUND, 6'd63, 0);
        add_row(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, KIND_ADDED, 0, 32'hFFFF_FFFE);
        add_row(MODE_ADD, 0, 0, 0, 1, KIND_ADDED, 1, 0);
        add_row(MODE_ADD, 100, 5, 0, 1, KIND_ADDED, 2, 105);
        add_row(MODE_ADD, 100, 5, 0, 1, KIND_ADDED, 3, 105);
        add_row(MODE_ADD, 50, 55, 0, 1, KIND_ADDED, 4, 105);
        add_row(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 0, KIND_NONE, 0, 0);
        add_row(MODE_DEL, 0, 0, 6'd1, 1, KIND_DELETED, 1, 0);
        add_row(MODE_DEL, 0, 0, 6'd1, 1, KIND_NOTFOUND, 1, 0);
        add_row(MODE_CHECK, 104, 0, 0, 1, KIND_NONE, 0, 0);
        add_row(MODE_CHECK, 105, 0, 0, 0, KIND_NONE, 0, 0);
        add_row(MODE_ADD, 7, 0, 0, 0, KIND_NONE, 0, 0);
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 0, 0, 0, KIND_NONE, 0, 0);
        foreach (directed[i]) begin
            send_request(directed[i].mode, directed[i].now_ms, directed[i].delay_ms,
                         directed[i].timer_id);
            if (directed[i].typed && pending_results.size() > 0 &&
                (pending_results[$].kind !== directed[i].kind ||
                 pending_results[$].id !== directed[i].id ||
                 pending_results[$].deadline !== directed[i].deadline)) begin
                $display("%0t: table row %0d expected %0d %0d %0d, predicted %0d %0d %0d",
                         $time, i, directed[i].kind, directed[i].id, directed[i].deadline,
                         pending_results[$].kind, pending_results[$].id,
                         pending_results[$].deadline);
                errors++;
            end
        end

        // Fill past capacity to reach the full answer, then fire everything
        for (int i = 0; i < CAP + 2; i++) send_request(MODE_ADD, $urandom, $urandom, 6'd0);
        drain_results();
        send_request(MODE_CHECK, 32'hFFFF_FFFF, 0, 6'd0);

        // Random traffic around a sliding time base
        base = $urandom;
        for (int i = 0; i < 320; i++) begin
            quiet_src = (i >= 150 && i < 220);
            quiet_snk = quiet_src;
            if (i == 300) drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_request(MODE_ADD, base, (sel < 5) ? rand_word() : $urandom_range(0, 400),
                             6'($urandom));
            else if (sel < 65)
                send_request(MODE_DEL, $urandom, $urandom,
                             ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                         : 6'($urandom_range(0, 15)));
            else if (sel < 95) begin
                base = base + $urandom_range(0, 150);
                send_request(MODE_CHECK, (sel < 68) ? rand_word() : base, $urandom,
                             6'($urandom));
            end else
                send_request(2'd3, $urandom, $urandom, 6'($urandom));
        end
        quiet_src = 0;
        quiet_snk = 0;
        drain_results();
        if (errors == 0)
            $display("min_heap_timer_queue_test: done, clean");
        else
            $display("min_heap_timer_queue_test: done, errors");
        $finish;
    end
endmodule
